// ----- design/assert_macros.svh -----
// Assertion helpers used by the sender window module.
// Each macro names its clock and active-low reset explicitly.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, masked while reset is asserted.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Antecedent in this cycle implies consequent in the next one.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/srsw_pkg.sv -----
// ----------------------------------------------------------------------------
// srsw_pkg
// Types and codes shared by the selective-repeat sender window modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srsw_pkg;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_ACK   = 2'd1;
    localparam logic [1:0] CMD_SCAN  = 2'd2;

    localparam int LEN_W     = 21;
    localparam int TIMEOUT_W = 16;
    localparam int TIME_W    = 32;

    typedef struct packed {
        logic [1:0]           command;
        logic [LEN_W-1:0]     block_bytes;
        logic                 final_block;
        logic [31:0]          ack_seq;
        logic                 ack_negative;
        logic                 ack_checksum_ok;
        logic [TIME_W-1:0]    now_seconds;
    } in_item_t;

    typedef struct packed {
        logic        is_send;
        logic [9:0]  seq_num;
        logic [10:0] frame_len;
        logic        eof_frame;
        logic        all_acked;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic              acked;
        logic              sent;
        logic [TIME_W-1:0] sent_time;
    } cell_data_t;

    typedef struct packed {
        logic clear;
        logic shift;
        logic mark_ack;
        logic clear_sent;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACK,
        ST_SLIDE,
        ST_SCAN,
        ST_STATUS
    } state_t;

endpackage

`default_nettype wire

// ----- design/srsw_cell.sv -----
// ----------------------------------------------------------------------------
// srsw_cell
// One window slot: acked and sent marks plus the time of the last transfer.
// Takes its right neighbour's contents on a shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srsw_cell (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire srsw_pkg::cell_ctrl_t ctrl,
    input  wire srsw_pkg::cell_data_t shift_in,
    output srsw_pkg::cell_data_t      data
);

    logic                          acked_reg;
    logic                          acked_next;
    logic                          sent_reg;
    logic                          sent_next;
    logic [srsw_pkg::TIME_W-1:0]   time_reg;
    logic [srsw_pkg::TIME_W-1:0]   time_next;

    always_comb
    begin
        acked_next = acked_reg;
        sent_next  = sent_reg;
        time_next  = time_reg;
        if (ctrl.clear)
        begin
            acked_next = 1'b0;
            sent_next  = 1'b0;
        end
        else if (ctrl.shift)
        begin
            acked_next = shift_in.acked;
            sent_next  = shift_in.sent;
            time_next  = shift_in.sent_time;
        end
        else
        begin
            if (ctrl.mark_ack)
            begin
                acked_next = 1'b1;
            end
            if (ctrl.clear_sent)
            begin
                sent_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acked_reg <= 1'b0;
            sent_reg  <= 1'b0;
        end
        else
        begin
            acked_reg <= acked_next;
            sent_reg  <= sent_next;
        end
    end

    // Time of transfer is only read behind a set sent mark: no reset.
    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
    end

    assign data.acked     = acked_reg;
    assign data.sent      = sent_reg;
    assign data.sent_time = time_reg;

endmodule

`default_nettype wire

// ----- design/selective_repeat_sender_window.sv -----
// ----------------------------------------------------------------------------
// selective_repeat_sender_window
// Sender window of a selective-repeat scheme built as a row of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   : command plus fields; start, acknowledgement or scan.
//   result channel : send requests, then one status item marked last.
//   cfg channel    : writes the 16-bit timeout; always ready.
// Neither a start nor an acknowledgement gives results.
// A scan slides the row one slot a cycle while the head slot is acked,
// then rotates every slot through the head, one slot a cycle while the
// output register is free, then emits the status item.
// Only one item is in work at a time; item_ready is high when idle.
// Results pass through a single output register; a stalled receiver
// holds the scan at its current slot until the register is taken.
// Reset empties the window, zeroes the block length and sets the
// timeout to 2 seconds. No clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module selective_repeat_sender_window #(
    parameter int WINDOW_SLOTS = 8,
    parameter int FRAME_BYTES  = 1024,
    parameter int BLOCK_FRAMES = 1024
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             item_valid,
    output logic                                  item_ready,
    input  wire srsw_pkg::in_item_t               item,
    output logic                                  result_valid,
    input  wire logic                             result_ready,
    output srsw_pkg::out_item_t                   result,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [srsw_pkg::TIMEOUT_W-1:0]   cfg_data
);

    localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    localparam int BASE_W = $clog2(BLOCK_FRAMES + 1);
    localparam int SEQ_W  = $clog2(BLOCK_FRAMES + WINDOW_SLOTS + 1);
    localparam logic [63:0] CAP_BYTES = 64'(FRAME_BYTES) * 64'(BLOCK_FRAMES);
    localparam logic [63:0] MAX_OFF =
        64'(FRAME_BYTES) * 64'(BLOCK_FRAMES + WINDOW_SLOTS + 1);
    localparam int OFF_W  = $clog2(MAX_OFF + 64'd1);
    localparam int CMP_W  = ((OFF_W > srsw_pkg::LEN_W) ? OFF_W : srsw_pkg::LEN_W) + 1;
    localparam int TW     = srsw_pkg::TIME_W;

    srsw_pkg::state_t               state_reg, state_next;
    logic [BASE_W-1:0]              base_reg, base_next;
    logic [OFF_W-1:0]               base_off_reg, base_off_next;
    logic [srsw_pkg::LEN_W-1:0]     len_reg, len_next;
    logic                           final_reg, final_next;
    logic [srsw_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [TW-1:0]                  now_reg, now_next;
    logic [SLOT_W-1:0]              slot_reg, slot_next;
    logic                           ack_hit_reg, ack_hit_next;
    logic                           ack_neg_reg, ack_neg_next;
    logic [OFF_W-1:0]               cur_off_reg, cur_off_next;
    logic [SEQ_W-1:0]               cur_seq_reg, cur_seq_next;
    logic [SLOT_W-1:0]              step_reg, step_next;
    logic                           result_valid_reg, result_valid_next;
    srsw_pkg::out_item_t            result_reg, result_next;

    srsw_pkg::cell_ctrl_t           cell_ctrl [WINDOW_SLOTS];
    srsw_pkg::cell_data_t           cell_q    [WINDOW_SLOTS];
    srsw_pkg::cell_data_t           tail_in;
    logic [WINDOW_SLOTS-1:0]        acked_vec;

    logic                           in_xfer;
    logic                           out_free;
    logic [TW-1:0]                  ack_diff;
    logic                           ack_in_win;
    logic [CMP_W-1:0]               len_cmp;
    logic [CMP_W-1:0]               cur_cmp;
    logic [CMP_W-1:0]               ack_off;
    logic [CMP_W-1:0]               rem_cmp;
    logic [CMP_W-1:0]               flen_cmp;
    logic [TW-1:0]                  elapsed;
    logic                           head_exists;
    logic                           head_due;

    // ------------------------------------------------------------------
    // Row of slot cells; the last one is fed from the head logic
    // ------------------------------------------------------------------
    for (genvar k = 0; k < WINDOW_SLOTS; k++)
    begin : g_cell
        srsw_pkg::cell_data_t nb_in;
        if (k == WINDOW_SLOTS - 1)
        begin : g_tail
            assign nb_in = tail_in;
        end
        else
        begin : g_mid
            assign nb_in = cell_q[k+1];
        end
        srsw_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl[k]),
            .shift_in (nb_in),
            .data     (cell_q[k])
        );
        assign acked_vec[k] = cell_q[k].acked;
    end

    assign item_ready   = (state_reg == srsw_pkg::ST_IDLE);
    assign in_xfer      = item_valid && item_ready;
    assign cfg_ready    = 1'b1;
    assign out_free     = !result_valid_reg || result_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Window test of an acknowledgement
    assign ack_diff   = item.ack_seq - TW'(base_reg);
    assign ack_in_win = (item.ack_seq >= TW'(base_reg)) &&
                        (ack_diff < TW'(WINDOW_SLOTS));
    assign len_cmp    = CMP_W'(len_reg);
    assign ack_off    = CMP_W'(base_off_reg) + CMP_W'(slot_reg) * CMP_W'(FRAME_BYTES);

    // Head slot during the scan
    assign cur_cmp     = CMP_W'(cur_off_reg);
    assign elapsed     = now_reg - cell_q[0].sent_time;
    assign head_exists = cur_cmp < len_cmp;
    assign head_due    = head_exists &&
                         (!cell_q[0].sent ||
                          (!cell_q[0].acked && (elapsed > TW'(timeout_reg))));
    assign rem_cmp     = len_cmp - cur_cmp;
    assign flen_cmp    = (rem_cmp > CMP_W'(FRAME_BYTES)) ? CMP_W'(FRAME_BYTES) : rem_cmp;

    always_comb
    begin
        state_next        = state_reg;
        base_next         = base_reg;
        base_off_next     = base_off_reg;
        len_next          = len_reg;
        final_next        = final_reg;
        now_next          = now_reg;
        slot_next         = slot_reg;
        ack_hit_next      = ack_hit_reg;
        ack_neg_next      = ack_neg_reg;
        cur_off_next      = cur_off_reg;
        cur_seq_next      = cur_seq_reg;
        step_next         = step_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        tail_in           = '0;
        for (int k = 0; k < WINDOW_SLOTS; k++)
        begin
            cell_ctrl[k] = '0;
        end

        case (state_reg)
            srsw_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    case (item.command)
                        srsw_pkg::CMD_START:
                        begin
                            // Saturate the block to the largest one the window can number
                            if (64'(item.block_bytes) > CAP_BYTES)
                            begin
                                len_next = srsw_pkg::LEN_W'(CAP_BYTES);
                            end
                            else
                            begin
                                len_next = item.block_bytes;
                            end
                            final_next    = item.final_block;
                            base_next     = '0;
                            base_off_next = '0;
                            for (int k = 0; k < WINDOW_SLOTS; k++)
                            begin
                                cell_ctrl[k].clear = 1'b1;
                            end
                        end
                        srsw_pkg::CMD_ACK:
                        begin
                            slot_next    = ack_diff[SLOT_W-1:0];
                            ack_hit_next = item.ack_checksum_ok && ack_in_win;
                            ack_neg_next = item.ack_negative;
                            state_next   = srsw_pkg::ST_ACK;
                        end
                        srsw_pkg::CMD_SCAN:
                        begin
                            now_next   = item.now_seconds;
                            state_next = srsw_pkg::ST_SLIDE;
                        end
                        default:
                        begin
                            state_next = srsw_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            srsw_pkg::ST_ACK:
            begin
                // Drop acks for frames past the end of the block
                if (ack_hit_reg && (ack_off < len_cmp))
                begin
                    for (int k = 0; k < WINDOW_SLOTS; k++)
                    begin
                        if (slot_reg == SLOT_W'(k))
                        begin
                            cell_ctrl[k].mark_ack   = !ack_neg_reg;
                            cell_ctrl[k].clear_sent = ack_neg_reg;
                        end
                    end
                end
                state_next = srsw_pkg::ST_IDLE;
            end

            srsw_pkg::ST_SLIDE:
            begin
                if (cell_q[0].acked)
                begin
                    // Advance past the acked head; empty slot enters at the tail
                    for (int k = 0; k < WINDOW_SLOTS; k++)
                    begin
                        cell_ctrl[k].shift = 1'b1;
                    end
                    base_next     = base_reg + BASE_W'(1);
                    base_off_next = base_off_reg + OFF_W'(FRAME_BYTES);
                end
                else
                begin
                    cur_off_next = base_off_reg;
                    cur_seq_next = SEQ_W'(base_reg);
                    step_next    = '0;
                    state_next   = srsw_pkg::ST_SCAN;
                end
            end

            srsw_pkg::ST_SCAN:
            begin
                if (out_free)
                begin
                    // Rotate the head to the tail, stamped if it goes out now
                    tail_in = cell_q[0];
                    if (head_due)
                    begin
                        tail_in.sent      = 1'b1;
                        tail_in.sent_time = now_reg;
                        result_valid_next = 1'b1;
                        result_next.is_send   = 1'b1;
                        result_next.seq_num   = 10'(cur_seq_reg);
                        result_next.frame_len = 11'(flen_cmp);
                        result_next.eof_frame = final_reg &&
                            ((cur_cmp + CMP_W'(FRAME_BYTES)) >= len_cmp);
                        result_next.all_acked = 1'b0;
                        result_next.last      = 1'b0;
                    end
                    for (int k = 0; k < WINDOW_SLOTS; k++)
                    begin
                        cell_ctrl[k].shift = 1'b1;
                    end
                    cur_off_next = cur_off_reg + OFF_W'(FRAME_BYTES);
                    cur_seq_next = cur_seq_reg + SEQ_W'(1);
                    step_next    = step_reg + SLOT_W'(1);
                    if (step_reg == SLOT_W'(WINDOW_SLOTS - 1))
                    begin
                        state_next = srsw_pkg::ST_STATUS;
                    end
                end
            end

            srsw_pkg::ST_STATUS:
            begin
                if (out_free)
                begin
                    result_valid_next     = 1'b1;
                    result_next.is_send   = 1'b0;
                    result_next.seq_num   = '0;
                    result_next.frame_len = '0;
                    result_next.eof_frame = 1'b0;
                    result_next.all_acked = CMP_W'(base_off_reg) >= len_cmp;
                    result_next.last      = 1'b1;
                    state_next            = srsw_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = srsw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= srsw_pkg::ST_IDLE;
            base_reg         <= '0;
            base_off_reg     <= '0;
            len_reg          <= '0;
            final_reg        <= 1'b0;
            timeout_reg      <= srsw_pkg::TIMEOUT_W'(2);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            base_reg         <= base_next;
            base_off_reg     <= base_off_next;
            len_reg          <= len_next;
            final_reg        <= final_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                timeout_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg     <= now_next;
        slot_reg    <= slot_next;
        ack_hit_reg <= ack_hit_next;
        ack_neg_reg <= ack_neg_next;
        cur_off_reg <= cur_off_next;
        cur_seq_reg <= cur_seq_next;
        step_reg    <= step_next;
        result_reg  <= result_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_CLKD(a_base_off_tracks_base, clk, rst_n,
        base_off_reg == OFF_W'(base_reg) * OFF_W'(FRAME_BYTES),
        "byte offset of the window base out of step with the base")
    `ASSERT_NEXT(a_slide_advances_base, clk, rst_n,
        (state_reg == srsw_pkg::ST_SLIDE) && cell_q[0].acked,
        base_reg == $past(base_reg) + BASE_W'(1),
        "slide of an acked head did not advance the base by one")
    `ASSERT_NEXT(a_start_empties_window, clk, rst_n,
        in_xfer && (item.command == srsw_pkg::CMD_START),
        (base_reg == '0) && ($countones(acked_vec) == 0),
        "start transfer left the window non-empty")
    `ASSERT_NEXT(a_status_closes_scan, clk, rst_n,
        (state_reg == srsw_pkg::ST_STATUS) && out_free,
        result_valid_reg && result_reg.last && !result_reg.is_send &&
        (state_reg == srsw_pkg::ST_IDLE),
        "scan did not finish with a status item")

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the selective-repeat sender window. A behavioural
// copy of the window (slot marks, send stamps, base, block length, timeout)
// predicts the send requests and status item of every scan. Directed tests
// cover frame layout, acknowledgement handling, saturation, time wrap and
// the timeout extremes; random block sessions follow under three idling mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int WIN           = 8;
    localparam int FRAME_LEN     = 1024;
    localparam int MAX_FRAMES    = 1024;
    localparam logic [srsw_pkg::LEN_W-1:0] BLOCK_CAP =
        srsw_pkg::LEN_W'(FRAME_LEN * MAX_FRAMES);
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 2 * WIN + 4;
    localparam int LIMIT_CYCLES  = 400000;

    logic                           clk;
    logic                           rst_n;
    logic                           item_valid;
    logic                           item_ready;
    srsw_pkg::in_item_t             item;
    logic                           result_valid;
    logic                           result_ready;
    srsw_pkg::out_item_t            result;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [srsw_pkg::TIMEOUT_W-1:0] cfg_data;

    // window as the block should hold it
    bit                             slot_acked [WIN];
    bit                             slot_sent [WIN];
    logic [srsw_pkg::TIME_W-1:0]    slot_stamp [WIN];
    logic [10:0]                    win_base = '0;
    logic [srsw_pkg::LEN_W-1:0]     blk_len = '0;
    bit                             blk_final = 1'b0;
    logic [srsw_pkg::TIMEOUT_W-1:0] timeout_s = 16'd2;

    srsw_pkg::out_item_t            send_plan_q[$];

    int                             fail_count = 0;
    int                             items_taken = 0;
    int                             send_idle_pct = 0;
    int                             sink_idle_pct = 0;
    int                             hold_request = 0;
    int                             hold_left = 0;
    int                             cycle_count = 0;
    logic [srsw_pkg::TIME_W-1:0]    now_s = '0;

    selective_repeat_sender_window u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int block_frames();
        return (int'(blk_len) + FRAME_LEN - 1) / FRAME_LEN;
    endfunction

    // Update the window for one accepted transfer and queue what it emits.
    function automatic void window_apply(srsw_pkg::in_item_t it);
        int                  count;
        int                  shift;
        int                  seq;
        int                  len;
        longint              aseq;
        bit                  due;
        srsw_pkg::out_item_t r;
        case (it.command)
            srsw_pkg::CMD_START:
            begin
                blk_len   = (it.block_bytes > BLOCK_CAP) ? BLOCK_CAP : it.block_bytes;
                blk_final = it.final_block;
                win_base  = '0;
                for (int i = 0; i < WIN; i++)
                begin
                    slot_acked[i] = 1'b0;
                    slot_sent[i]  = 1'b0;
                    slot_stamp[i] = '0;
                end
            end
            srsw_pkg::CMD_ACK:
            begin
                count = block_frames();
                aseq  = it.ack_seq;
                if (it.ack_checksum_ok && aseq >= longint'(win_base)
                    && aseq < longint'(win_base) + WIN && aseq < count)
                begin
                    if (it.ack_negative)
                        slot_sent[aseq - longint'(win_base)] = 1'b0;
                    else
                        slot_acked[aseq - longint'(win_base)] = 1'b1;
                end
            end
            srsw_pkg::CMD_SCAN:
            begin
                count = block_frames();
                shift = 0;
                while (shift < WIN && slot_acked[shift])
                    shift++;
                if (shift > 0)
                begin
                    for (int i = 0; i < WIN; i++)
                    begin
                        if (i + shift < WIN)
                        begin
                            slot_acked[i] = slot_acked[i + shift];
                            slot_sent[i]  = slot_sent[i + shift];
                            slot_stamp[i] = slot_stamp[i + shift];
                        end
                        else
                        begin
                            slot_acked[i] = 1'b0;
                            slot_sent[i]  = 1'b0;
                        end
                    end
                    win_base = win_base + 11'(shift);
                end
                for (int i = 0; i < WIN; i++)
                begin
                    seq = int'(win_base) + i;
                    if (seq < count)
                    begin
                        due = !slot_sent[i] || (!slot_acked[i]
                              && (it.now_seconds - slot_stamp[i])
                                 > srsw_pkg::TIME_W'(timeout_s));
                        if (due)
                        begin
                            len = int'(blk_len) - seq * FRAME_LEN;
                            if (len > FRAME_LEN)
                                len = FRAME_LEN;
                            r           = '0;
                            r.is_send   = 1'b1;
                            r.seq_num   = 10'(seq);
                            r.frame_len = 11'(len);
                            r.eof_frame = (seq + 1 == count) && blk_final;
                            send_plan_q.push_back(r);
                            slot_sent[i]  = 1'b1;
                            slot_stamp[i] = it.now_seconds;
                        end
                    end
                end
                r           = '0;
                r.all_acked = (int'(win_base) >= count);
                r.last      = 1'b1;
                send_plan_q.push_back(r);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        srsw_pkg::out_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (send_plan_q.size() == 0)
            begin
                $error("result %h arrived with nothing pending", result);
                fail_count++;
            end
            else
            begin
                want = send_plan_q.pop_front();
                check_field("is_send", want.is_send, result.is_send);
                check_field("seq_num", want.seq_num, result.seq_num);
                check_field("frame_len", want.frame_len, result.frame_len);
                check_field("eof_frame", want.eof_frame, result.eof_frame);
                check_field("all_acked", want.all_acked, result.all_acked);
                check_field("last", want.last, result.last);
            end
        end
    end

    // Receiver: random stalls, or a long hold when one is requested.
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                result_ready = 1'b0;
                hold_left--;
            end
            else
                result_ready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Every task below starts and returns just after a falling edge.
    task automatic send_item(input srsw_pkg::in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        item       = it;
        item_valid = 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        window_apply(it);
        items_taken++;
        @(negedge clk);
        item_valid = 1'b0;
    endtask

    // Unused fields carry random values.
    function automatic srsw_pkg::in_item_t make_item(logic [1:0] cmd);
        srsw_pkg::in_item_t it;
        it.command         = cmd;
        it.block_bytes     = srsw_pkg::LEN_W'($urandom);
        it.final_block     = 1'($urandom);
        it.ack_seq         = $urandom;
        it.ack_negative    = 1'($urandom);
        it.ack_checksum_ok = 1'($urandom);
        it.now_seconds     = $urandom;
        return it;
    endfunction

    task automatic send_start(input logic [srsw_pkg::LEN_W-1:0] bytes, input logic fin);
        srsw_pkg::in_item_t it;
        it             = make_item(srsw_pkg::CMD_START);
        it.block_bytes = bytes;
        it.final_block = fin;
        send_item(it);
    endtask

    task automatic send_ack(input logic [31:0] seq, input logic neg, input logic ok);
        srsw_pkg::in_item_t it;
        it                 = make_item(srsw_pkg::CMD_ACK);
        it.ack_seq         = seq;
        it.ack_negative    = neg;
        it.ack_checksum_ok = ok;
        send_item(it);
    endtask

    task automatic send_scan(input logic [srsw_pkg::TIME_W-1:0] at);
        srsw_pkg::in_item_t it;
        it             = make_item(srsw_pkg::CMD_SCAN);
        it.now_seconds = at;
        send_item(it);
    endtask

    // Drain every pending result, then let a trailing start or ack finish.
    task automatic settle();
        while (send_plan_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_timeout(input logic [srsw_pkg::TIMEOUT_W-1:0] value);
        settle();
        cfg_data  = value;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        timeout_s = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic test_empty_after_reset();
        send_scan(32'd0);
        send_item(make_item(CMD_UNUSED));
    endtask

    task automatic test_frame_layout();
        send_start('0, 1'b1);
        send_scan(32'd3);
        // exact multiple: both frames full, no end-of-file flag
        send_start(srsw_pkg::LEN_W'(2 * FRAME_LEN), 1'b0);
        send_scan(32'd7);
    endtask

    task automatic test_ack_handling();
        send_start(21'd2500, 1'b1);
        send_scan(32'd100);
        send_ack(32'd1, 1'b0, 1'b1);
        send_ack(32'd0, 1'b0, 1'b0);
        send_ack(32'd9, 1'b0, 1'b1);
        send_ack(32'd3, 1'b0, 1'b1);
        send_ack(32'd2, 1'b1, 1'b1);
        send_scan(32'd101);
        // negative on an acked slot: resend, acked mark kept
        send_ack(32'd1, 1'b1, 1'b1);
        send_scan(32'd102);
        send_ack(32'd0, 1'b0, 1'b1);
        send_ack(32'd2, 1'b0, 1'b1);
        send_scan(32'd300);
    endtask

    task automatic test_saturation_and_wrap();
        send_start('1, 1'b1);
        send_scan(32'hFFFF_FFFE);
        send_scan(32'd1);
    endtask

    task automatic test_timeout_extremes();
        write_timeout('0);
        send_start(21'd1000, 1'b1);
        send_scan(32'd5);
        send_scan(32'd5);
        send_scan(32'd6);
        write_timeout('1);
        send_scan(32'd6 + 32'd65535);
        send_scan(32'd6 + 32'd65536);
    endtask

    task automatic test_output_backpressure();
        write_timeout('0);
        send_start(srsw_pkg::LEN_W'(20 * FRAME_LEN), 1'b1);
        hold_request = 300;
        // hold the receiver while full scans pile up behind it
        for (int k = 0; k < 6; k++)
            send_scan(32'(1000 + k));
        settle();
    endtask

    task automatic test_random_sessions(input int send_pct, input int sink_pct,
                                        input logic [srsw_pkg::TIMEOUT_W-1:0] tmo,
                                        input int quota);
        int                         target;
        int                         pick;
        int                         nscan;
        int                         nack;
        logic [srsw_pkg::LEN_W-1:0] bytes;
        send_idle_pct = send_pct;
        sink_idle_pct = sink_pct;
        write_timeout(tmo);
        now_s  = $urandom;
        target = items_taken + quota;
        while (items_taken < target)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                bytes = '0;
            else if (pick < 80)
                bytes = srsw_pkg::LEN_W'($urandom_range(1, 12 * FRAME_LEN));
            else if (pick < 90)
                bytes = srsw_pkg::LEN_W'($urandom);
            else
                bytes = srsw_pkg::LEN_W'(FRAME_LEN * $urandom_range(1, 12));
            send_start(bytes, 1'($urandom));
            nscan = $urandom_range(3, 10);
            for (int s = 0; s < nscan && items_taken < target; s++)
            begin
                send_scan(now_s);
                nack = $urandom_range(0, 6);
                for (int a = 0; a < nack && items_taken < target; a++)
                begin
                    pick = $urandom_range(99);
                    if (pick < 70)
                        send_ack(32'(win_base) + 32'($urandom_range(0, WIN + 1)) - 32'd1,
                                 ($urandom_range(9) == 0), ($urandom_range(9) != 0));
                    else if (pick < 90)
                        send_ack($urandom, 1'($urandom), 1'($urandom));
                    else
                        send_item(make_item(CMD_UNUSED));
                end
                if ($urandom_range(19) == 0)
                    now_s = now_s + $urandom;
                else
                    now_s = now_s + $urandom_range(0, 4);
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        for (int i = 0; i < WIN; i++)
        begin
            slot_acked[i] = 1'b0;
            slot_sent[i]  = 1'b0;
            slot_stamp[i] = '0;
        end
        send_idle_pct = 23;
        sink_idle_pct = 45;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_empty_after_reset();
        test_frame_layout();
        test_ack_handling();
        test_saturation_and_wrap();
        test_timeout_extremes();
        test_output_backpressure();
        test_random_sessions(23, 45, 16'd2, 72);
        test_random_sessions(45, 23, 16'($urandom_range(0, 6)), 72);
        test_random_sessions(0, 0, 16'($urandom_range(0, 6)), 70);

        settle();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
